@@ design/scr_pkg.sv @@
// Package: shared types, constants and helper functions for the serial command responder.
package scr_pkg;

	localparam int MAX_PAYLOAD_DEF = 64;
	localparam int ADC_BITS_DEF    = 10;
	localparam int PERIOD_MIN_DEF  = 10;
	localparam int PERIOD_MAX_DEF  = 5000;

	localparam int NUM_CH     = 4;
	localparam int ANALOG_W   = 10;
	localparam int TICK_W     = 13;
	localparam int IDX_W      = 5;
	localparam int RESP_FIXED = 6;
	localparam int FRAME_LEN  = 20;
	localparam int SW_PERIOD_RST = 100;
	localparam int AN_PERIOD_RST = 50;

	localparam logic [7:0] SYNC1    = 8'h55;
	localparam logic [7:0] SYNC2    = 8'hAA;
	localparam logic [7:0] RSP_TAG  = 8'hAB;
	localparam logic [7:0] FRM_TAG1 = 8'h7A;
	localparam logic [7:0] FRM_TAG2 = 8'h7B;
	localparam logic [7:0] FRM_END  = 8'h7C;
	localparam logic [3:0] NIBBLE_MASK = 4'h0F;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_CHK   = 2'd1;
	localparam logic [1:0] ST_BAD_PARAM = 2'd2;
	localparam logic [1:0] ST_UNKNOWN   = 2'd3;

	localparam logic [7:0] CMD_NONE      = 8'd0;
	localparam logic [7:0] CMD_SET_LAMPS = 8'd1;
	localparam logic [7:0] CMD_GET_SW    = 8'd2;
	localparam logic [7:0] CMD_SET_SWP   = 8'd3;
	localparam logic [7:0] CMD_GET_SWP   = 8'd4;
	localparam logic [7:0] CMD_STREAM    = 8'd5;
	localparam logic [7:0] CMD_SNAPSHOT  = 8'd6;
	localparam logic [7:0] CMD_IDENT     = 8'd7;
	localparam logic [7:0] CMD_SET_ANP   = 8'd8;
	localparam logic [7:0] CMD_GET_ANP   = 8'd9;

	localparam logic [3:0] INFO_LEN = 4'd9;
	localparam logic [7:0] INFO_XOR = 8'h04;

	typedef enum logic [2:0] {
		PH_H1,
		PH_H2,
		PH_CMD,
		PH_LEN,
		PH_PAY,
		PH_CHK
	} phase_t;

	typedef struct packed {
		logic                             command;
		logic [7:0]                       rx_byte;
		logic [3:0]                       switch_levels;
		logic [NUM_CH-1:0][ANALOG_W-1:0]  analog;
	} item_t;

	typedef struct packed {
		logic       resp;
		logic [1:0] status;
		logic [7:0] cmd;
		logic [3:0] len;
		logic       info;
		logic [7:0] p0;
		logic [7:0] p1;
		logic [7:0] chk;
		logic       frame;
		logic [7:0] digital;
		logic [3:0] lamp;
	} desc_t;

	function automatic logic [7:0] info_byte(input logic [3:0] i);
		logic [7:0] b;
		case (i)
			4'd0: b = 8'h4C;
			4'd1: b = 8'h41;
			4'd2: b = 8'h42;
			4'd3: b = 8'h32;
			4'd4: b = 8'h20;
			4'd5: b = 8'h76;
			4'd6: b = 8'h31;
			4'd7: b = 8'h2E;
			4'd8: b = 8'h30;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ design/scr_core.sv @@
// Frame parser, command execution and tick-driven sampling, updated once per transaction.
module scr_core #(
	parameter int MAX_PAYLOAD = scr_pkg::MAX_PAYLOAD_DEF,
	parameter int ADC_BITS    = scr_pkg::ADC_BITS_DEF,
	parameter int PERIOD_MIN  = scr_pkg::PERIOD_MIN_DEF,
	parameter int PERIOD_MAX  = scr_pkg::PERIOD_MAX_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        fire,
	input  scr_pkg::item_t                              item,
	output scr_pkg::desc_t                              desc,
	output logic [scr_pkg::NUM_CH-1:0][ADC_BITS-1:0]    adc_out,
	output logic                                        has_out
);

	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
	localparam int TW    = scr_pkg::TICK_W;
	localparam int NCH   = scr_pkg::NUM_CH;

	scr_pkg::phase_t          ph_q, ph_n;
	logic [7:0]               cmd_q, cmd_n;
	logic [7:0]               len_q, len_n;
	logic [CNT_W-1:0]         cnt_q, cnt_n;
	logic [1:0][7:0]          pay_q, pay_n;
	logic [7:0]               chk_q, chk_n;
	logic [3:0]               led_q, led_n;
	logic [3:0]               dip_q, dip_n;
	logic [NCH-1:0][ADC_BITS-1:0] adc_q, adc_n, adc_live;
	logic [TW-1:0]            swp_q, swp_n;
	logic [TW-1:0]            anp_q, anp_n;
	logic                     stream_q, stream_n;
	logic [2:0][TW-1:0]       el_q, el_n, e_inc;

	logic [1:0]               ex_status;
	logic [3:0]               ex_len;
	logic                     ex_info;
	logic [7:0]               ex_p0, ex_p1;
	logic                     ex_frame;
	logic [3:0]               ex_led, ex_dip;
	logic [TW-1:0]            ex_swp, ex_anp;
	logic                     ex_stream;
	logic [7:0]               need;
	logic [15:0]              pv;
	logic [TW-1:0]            clamp_ms;
	logic [TW-1:0]            tx_per;
	logic [CNT_W-1:0]         cnt_inc;
	logic [15:0]              ext;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			ext = 16'(item.analog[c]);
			adc_live[c] = ext[ADC_BITS-1:0];
		end
	end

	always_comb begin
		pv = {pay_q[1], pay_q[0]};
		if (pv < 16'(PERIOD_MIN)) begin
			clamp_ms = TW'(PERIOD_MIN);
		end else if (pv > 16'(PERIOD_MAX)) begin
			clamp_ms = TW'(PERIOD_MAX);
		end else begin
			clamp_ms = pv[TW-1:0];
		end
	end

	// Execute the command held in cmd_q/len_q/pay_q.
	always_comb begin
		ex_status = scr_pkg::ST_OK;
		ex_len    = 4'd0;
		ex_info   = 1'b0;
		ex_p0     = 8'd0;
		ex_p1     = 8'd0;
		ex_frame  = 1'b0;
		ex_led    = led_q;
		ex_dip    = dip_q;
		ex_swp    = swp_q;
		ex_anp    = anp_q;
		ex_stream = stream_q;
		if (cmd_q == scr_pkg::CMD_SET_LAMPS || cmd_q == scr_pkg::CMD_STREAM) begin
			need = 8'd1;
		end else if (cmd_q == scr_pkg::CMD_SET_SWP || cmd_q == scr_pkg::CMD_SET_ANP) begin
			need = 8'd2;
		end else begin
			need = 8'd0;
		end
		if (cmd_q == scr_pkg::CMD_NONE || cmd_q > scr_pkg::CMD_GET_ANP) begin
			ex_status = scr_pkg::ST_UNKNOWN;
		end else if (len_q != need) begin
			ex_status = scr_pkg::ST_BAD_PARAM;
		end else begin
			case (cmd_q)
				scr_pkg::CMD_SET_LAMPS: begin
					ex_led = pay_q[0][3:0] & scr_pkg::NIBBLE_MASK;
					ex_len = 4'd1;
					ex_p0  = {4'd0, ex_led};
				end
				scr_pkg::CMD_GET_SW: begin
					ex_dip = item.switch_levels;
					ex_len = 4'd1;
					ex_p0  = {4'd0, ex_dip};
				end
				scr_pkg::CMD_SET_SWP: begin
					ex_swp = clamp_ms;
					ex_len = 4'd2;
					ex_p0  = clamp_ms[7:0];
					ex_p1  = 8'(clamp_ms >> 8);
				end
				scr_pkg::CMD_SET_ANP: begin
					ex_anp = clamp_ms;
					ex_len = 4'd2;
					ex_p0  = clamp_ms[7:0];
					ex_p1  = 8'(clamp_ms >> 8);
				end
				scr_pkg::CMD_GET_SWP: begin
					ex_len = 4'd2;
					ex_p0  = swp_q[7:0];
					ex_p1  = 8'(swp_q >> 8);
				end
				scr_pkg::CMD_GET_ANP: begin
					ex_len = 4'd2;
					ex_p0  = anp_q[7:0];
					ex_p1  = 8'(anp_q >> 8);
				end
				scr_pkg::CMD_STREAM: begin
					ex_stream = (pay_q[0] != 8'd0);
					ex_len    = 4'd1;
					ex_p0     = {7'd0, ex_stream};
				end
				scr_pkg::CMD_SNAPSHOT: begin
					ex_frame = 1'b1;
				end
				scr_pkg::CMD_IDENT: begin
					ex_len  = scr_pkg::INFO_LEN;
					ex_info = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		ph_n     = ph_q;
		cmd_n    = cmd_q;
		len_n    = len_q;
		cnt_n    = cnt_q;
		pay_n    = pay_q;
		chk_n    = chk_q;
		led_n    = led_q;
		dip_n    = dip_q;
		adc_n    = adc_q;
		swp_n    = swp_q;
		anp_n    = anp_q;
		stream_n = stream_q;
		el_n     = el_q;
		desc     = '0;
		cnt_inc  = cnt_q + 1'b1;
		tx_per   = (swp_q < anp_q) ? swp_q : anp_q;
		for (int i = 0; i < 3; i++) begin
			e_inc[i] = (el_q[i] == {TW{1'b1}}) ? el_q[i] : el_q[i] + 1'b1;
		end
		if (item.command) begin
			el_n = e_inc;
			if (e_inc[0] >= swp_q) begin
				el_n[0] = '0;
				dip_n   = item.switch_levels;
			end
			if (e_inc[1] >= anp_q) begin
				el_n[1] = '0;
				adc_n   = adc_live;
			end
			if (stream_q && e_inc[2] >= tx_per) begin
				el_n[2]    = '0;
				desc.frame = 1'b1;
			end
		end else begin
			case (ph_q)
				scr_pkg::PH_H1: begin
					ph_n = (item.rx_byte == scr_pkg::SYNC1) ? scr_pkg::PH_H2 : scr_pkg::PH_H1;
				end
				scr_pkg::PH_H2: begin
					ph_n = (item.rx_byte == scr_pkg::SYNC2) ? scr_pkg::PH_CMD : scr_pkg::PH_H1;
				end
				scr_pkg::PH_CMD: begin
					cmd_n = item.rx_byte;
					chk_n = item.rx_byte;
					ph_n  = scr_pkg::PH_LEN;
				end
				scr_pkg::PH_LEN: begin
					len_n = item.rx_byte;
					chk_n = chk_q ^ item.rx_byte;
					if (item.rx_byte > 8'(MAX_PAYLOAD)) begin
						desc.resp   = 1'b1;
						desc.status = scr_pkg::ST_BAD_PARAM;
						desc.cmd    = cmd_q;
						ph_n        = scr_pkg::PH_H1;
					end else if (item.rx_byte == 8'd0) begin
						ph_n = scr_pkg::PH_CHK;
					end else begin
						cnt_n = '0;
						ph_n  = scr_pkg::PH_PAY;
					end
				end
				scr_pkg::PH_PAY: begin
					if (cnt_q < CNT_W'(2)) begin
						pay_n[cnt_q[0]] = item.rx_byte;
					end
					chk_n = chk_q ^ item.rx_byte;
					cnt_n = cnt_inc;
					if (8'(cnt_inc) >= len_q) begin
						ph_n = scr_pkg::PH_CHK;
					end
				end
				scr_pkg::PH_CHK: begin
					desc.resp = 1'b1;
					desc.cmd  = cmd_q;
					if (chk_q == item.rx_byte) begin
						desc.status = ex_status;
						desc.len    = ex_len;
						desc.info   = ex_info;
						desc.p0     = ex_p0;
						desc.p1     = ex_p1;
						desc.frame  = ex_frame;
						led_n       = ex_led;
						dip_n       = ex_dip;
						swp_n       = ex_swp;
						anp_n       = ex_anp;
						stream_n    = ex_stream;
					end else begin
						desc.status = scr_pkg::ST_BAD_CHK;
					end
					ph_n = scr_pkg::PH_H1;
				end
				default: begin
					ph_n = scr_pkg::PH_H1;
				end
			endcase
		end
		if (desc.info) begin
			desc.chk = {6'd0, desc.status} ^ desc.cmd ^ {4'd0, desc.len} ^ scr_pkg::INFO_XOR;
		end else begin
			desc.chk = {6'd0, desc.status} ^ desc.cmd ^ {4'd0, desc.len}
				^ ((desc.len >= 4'd1) ? desc.p0 : 8'd0)
				^ ((desc.len >= 4'd2) ? desc.p1 : 8'd0);
		end
		desc.digital = {dip_n, led_n};
		desc.lamp    = led_n;
		adc_out      = adc_n;
		has_out      = desc.resp | desc.frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= scr_pkg::PH_H1;
			cmd_q    <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
			chk_q    <= '0;
			led_q    <= '0;
			dip_q    <= '0;
			adc_q    <= '0;
			swp_q    <= TW'(scr_pkg::SW_PERIOD_RST);
			anp_q    <= TW'(scr_pkg::AN_PERIOD_RST);
			stream_q <= 1'b0;
			el_q     <= '0;
		end else if (fire) begin
			ph_q     <= ph_n;
			cmd_q    <= cmd_n;
			len_q    <= len_n;
			cnt_q    <= cnt_n;
			chk_q    <= chk_n;
			led_q    <= led_n;
			dip_q    <= dip_n;
			adc_q    <= adc_n;
			swp_q    <= swp_n;
			anp_q    <= anp_n;
			stream_q <= stream_n;
			el_q     <= el_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pay_q <= pay_n;
		end
	end

endmodule

@@ design/scr_tx.sv @@
// Result register and byte serializer for status responses and data frames.
module scr_tx #(
	parameter int ADC_BITS = scr_pkg::ADC_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      load,
	input  scr_pkg::desc_t                            desc_in,
	input  logic [scr_pkg::NUM_CH-1:0][ADC_BITS-1:0]  adc_in,
	output logic                                      free,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [7:0]                                out_byte,
	output logic                                      out_last,
	output logic [3:0]                                out_lamp
);

	localparam int IW = scr_pkg::IDX_W;

	scr_pkg::desc_t                                desc_q;
	logic [scr_pkg::NUM_CH-1:0][ADC_BITS-1:0]      adc_q;
	logic                                          valid_q;
	logic [IW-1:0]                                 idx_q;
	logic [IW-1:0]                                 nr, tot, j, m, k5;
	logic [15:0]                                   v;
	logic                                          xfer;

	always_comb begin
		nr       = desc_q.resp ? IW'(scr_pkg::RESP_FIXED) + IW'(desc_q.len) : '0;
		tot      = nr + (desc_q.frame ? IW'(scr_pkg::FRAME_LEN) : '0);
		out_last = (idx_q == tot - 1'b1);
		xfer     = valid_q && out_ready;
		free     = !valid_q || (xfer && out_last);
		j        = idx_q - nr;
		m        = j - IW'(3);
		k5       = idx_q - IW'(5);
		v        = m[3] ? 16'(adc_q[m[2:1]] >> 1) : 16'(adc_q[m[2:1]]);
		if (idx_q < nr) begin
			case (idx_q)
				5'd0: out_byte = scr_pkg::SYNC1;
				5'd1: out_byte = scr_pkg::RSP_TAG;
				5'd2: out_byte = {6'd0, desc_q.status};
				5'd3: out_byte = desc_q.cmd;
				5'd4: out_byte = {4'd0, desc_q.len};
				default: begin
					if (idx_q == IW'(5) + IW'(desc_q.len)) begin
						out_byte = desc_q.chk;
					end else if (desc_q.info) begin
						out_byte = scr_pkg::info_byte(k5[3:0]);
					end else begin
						out_byte = (idx_q == IW'(5)) ? desc_q.p0 : desc_q.p1;
					end
				end
			endcase
		end else begin
			case (j)
				5'd0:  out_byte = scr_pkg::FRM_TAG1;
				5'd1:  out_byte = scr_pkg::FRM_TAG2;
				5'd2:  out_byte = desc_q.digital;
				5'd19: out_byte = scr_pkg::FRM_END;
				default: out_byte = m[0] ? v[15:8] : v[7:0];
			endcase
		end
		out_valid = valid_q;
		out_lamp  = desc_q.lamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (xfer) begin
			if (out_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= desc_in;
			adc_q  <= adc_in;
		end
	end

endmodule

@@ design/serial_command_responder.sv @@
// Top level of the serial command responder: input register, core and byte serializer.
//
//   Channel   Direction  Handshake           Payload
//   s_*       in         s_tvalid/s_tready   tuser: command; tdata: byte, switches, 4 channels
//   m_*       out        m_tvalid/m_tready   tdata: out_byte, lamp_mask; tlast: last_of_run
//
// A transaction that causes no output bytes is taken every cycle.
// Output bytes are handed off under m_tvalid/m_tready; an item with output waits in the input register
// until the serializer has handed off the last byte of the previous run (at most 26).
// Reset clears all control state at once; there is no clearing pass.
module serial_command_responder #(
	parameter int MAX_PAYLOAD = scr_pkg::MAX_PAYLOAD_DEF,
	parameter int ADC_BITS    = scr_pkg::ADC_BITS_DEF,
	parameter int PERIOD_MIN  = scr_pkg::PERIOD_MIN_DEF,
	parameter int PERIOD_MAX  = scr_pkg::PERIOD_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // rx_byte, switch_levels, analog_ch0..analog_ch3, zero fill
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_byte, lamp_mask, zero fill
	output logic        m_tlast
);

	localparam int NCH = scr_pkg::NUM_CH;

	scr_pkg::item_t                 item_s1;
	logic                           valid_s1;
	scr_pkg::desc_t                 desc;
	logic [NCH-1:0][ADC_BITS-1:0]   adc_out;
	logic                           has_out;
	logic                           free;
	logic                           fire;
	logic [7:0]                     out_byte;
	logic [3:0]                     out_lamp;

	assign fire     = valid_s1 && (!has_out || free);
	assign s_tready = !valid_s1 || fire;
	assign m_tdata  = {4'd0, out_lamp, out_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command       <= s_tuser;
			item_s1.rx_byte       <= s_tdata[7:0];
			item_s1.switch_levels <= s_tdata[11:8];
			item_s1.analog[0]     <= s_tdata[21:12];
			item_s1.analog[1]     <= s_tdata[31:22];
			item_s1.analog[2]     <= s_tdata[41:32];
			item_s1.analog[3]     <= s_tdata[51:42];
		end
	end

	scr_core #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.ADC_BITS    (ADC_BITS),
		.PERIOD_MIN  (PERIOD_MIN),
		.PERIOD_MAX  (PERIOD_MAX)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.desc    (desc),
		.adc_out (adc_out),
		.has_out (has_out)
	);

	scr_tx #(
		.ADC_BITS (ADC_BITS)
	) u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && has_out),
		.desc_in   (desc),
		.adc_in    (adc_out),
		.free      (free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (out_byte),
		.out_last  (m_tlast),
		.out_lamp  (out_lamp)
	);

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (!$past(m_tvalid) || $past(m_tready && m_tlast))
		|-> (m_tdata[7:0] == scr_pkg::SYNC1 || m_tdata[7:0] == scr_pkg::FRM_TAG1))
		else $error("output run does not start with a header byte");

	a_run_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("output run broke off before its last byte");

	a_lamp_steady: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tdata[11:8] == $past(m_tdata[11:8]))
		else $error("lamp mask changed within one output run");

endmodule
